@@ rtl/core/cjdr_pkg.sv @@
// cjdr_pkg: shared types, codes and constants of the closest jet delta-r matcher
// depends on nothing; imported by every module of the block
`default_nettype none

package cjdr_pkg;

  // item kinds on the input channel
  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_QUERY = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_CONE_RADIUS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_MATCH    = 1'b1;
  localparam int unsigned CFG_DATA_W = 12;

  // configuration reset values (0.4 and 0.5 in 1/1024 units)
  localparam logic [CFG_DATA_W-1:0] CONE_RADIUS_RST = 12'd410;
  localparam logic [CFG_DATA_W-1:0] NO_MATCH_RST    = 12'd512;

  // table depth default
  localparam int unsigned MAX_JETS_DEF = 32;

  // field widths
  localparam int unsigned ETA_W  = 16;
  localparam int unsigned PHI_W  = 13;
  localparam int unsigned PT_W   = 16;
  localparam int unsigned MASS_W = 16;
  localparam int unsigned DR_W   = 12;
  localparam int unsigned DIFF_W = 13;

  // squared distance below cone^2, and its root
  localparam int unsigned RAD_W  = 2 * CFG_DATA_W;
  localparam int unsigned ROOT_W = CFG_DATA_W;

  // pi and 2*pi in 1/1024 rad
  localparam int PI_FX     = 3217;
  localparam int TWO_PI_FX = 6434;

  // controller to datapath
  typedef struct packed {
    logic load;        // store the accepted jet word
    logic clear;       // empty the table
    logic start;       // latch the muon, reset the best candidate
    logic walk;        // issue table reads for the walk
    logic root_start;  // start the square root on the best distance
    logic fetch;       // read pt and mass of the best jet
    logic emit;        // load the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic walk_end;   // all stored jets issued
    logic pipe_busy;  // distance pipeline still holds a jet
    logic root_busy;  // square root unit iterating
    logic out_full;   // output word waits and is not taken this cycle
  } status_t;

endpackage

`default_nettype wire

@@ rtl/core/closest_jet_delta_r_match.sv @@
// closest_jet_delta_r_match: top level of the closest jet delta-r matcher
// depends on cjdr_pkg, cjdr_ctrl, cjdr_dpath (and cjdr_sqrt below it)
//
//   channel  | handshake             | word
//   ---------+-----------------------+-------------------------------------------
//   input    | in_valid / in_ready   | kind, eta, phi, pt, mass
//   output   | out_valid / out_ready | dr, deta, dphi, jet_pt, jet_mass, matched,
//            |                       | jets_dropped
//   config   | cfg_we                | cfg_index, cfg_data
//
// loads, clears and unused kinds leave the sequencer idle and ready for the next word
// a query walks the stored jets, drains the distance pipeline, runs the square root
// step by step, fetches pt and mass of the best jet and loads the output register,
// and takes the next word only once its result is loaded
// reset empties the table, clears the drop flag and restores the cone and no-match
// a result waiting in the output register does not block loads or clears; a
// query runs up to its pt/mass fetch and then holds until the output register is free
`default_nettype none

module closest_jet_delta_r_match
  import cjdr_pkg::*;
#(
  parameter int unsigned MAX_JETS = MAX_JETS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output      logic                     in_ready,
  input  wire logic [1:0]               kind,
  input  wire logic signed [ETA_W-1:0]  eta,
  input  wire logic signed [PHI_W-1:0]  phi,
  input  wire logic [PT_W-1:0]          pt,
  input  wire logic [MASS_W-1:0]        mass,
  output      logic                     out_valid,
  input  wire logic                     out_ready,
  output      logic [DR_W-1:0]          dr,
  output      logic signed [DIFF_W-1:0] deta,
  output      logic signed [DIFF_W-1:0] dphi,
  output      logic [PT_W-1:0]          jet_pt,
  output      logic [MASS_W-1:0]        jet_mass,
  output      logic                     matched,
  output      logic                     jets_dropped,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [CFG_DATA_W-1:0]    cfg_data
);

  cmd_t    cmd;
  status_t status;

  // sequencer
  cjdr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .kind     (kind),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // table, distance pipeline and output register
  cjdr_dpath #(
    .MAX_JETS (MAX_JETS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .eta          (eta),
    .phi          (phi),
    .pt           (pt),
    .mass         (mass),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .dr           (dr),
    .deta         (deta),
    .dphi         (dphi),
    .jet_pt       (jet_pt),
    .jet_mass     (jet_mass),
    .matched      (matched),
    .jets_dropped (jets_dropped)
  );

endmodule

`default_nettype wire

@@ rtl/core/cjdr_sqrt.sv @@
// cjdr_sqrt: iterative floor square root, two radicand bits per cycle
// depends on cjdr_pkg
`default_nettype none

module cjdr_sqrt
  import cjdr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [RAD_W-1:0]  radicand,
  output      logic              busy,
  output      logic [ROOT_W-1:0] root
);

  localparam int unsigned CNT_W = $clog2(ROOT_W + 1);
  localparam int unsigned REM_W = ROOT_W + 4;
  localparam int unsigned TRY_W = ROOT_W + 2;

  logic [CNT_W-1:0] cnt;
  logic [RAD_W-1:0] xs;
  logic [REM_W-1:0] rem;
  logic [REM_W-1:0] rem_sh;
  logic [TRY_W-1:0] trial;
  logic             take;

  // one result bit per step
  always_comb begin
    rem_sh = {rem[REM_W-3:0], xs[RAD_W-1 -: 2]};
    trial  = {root, 2'b01};
    take   = (rem_sh >= REM_W'(trial));
  end

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(ROOT_W);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  // remainder, root and radicand shift
  always_ff @(posedge clk) begin
    if (start) begin
      xs   <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (cnt != '0) begin
      xs <= {xs[RAD_W-3:0], 2'b00};
      if (take) begin
        rem  <= rem_sh - REM_W'(trial);
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign busy = (cnt != '0);

endmodule

`default_nettype wire

@@ rtl/core/cjdr_ctrl.sv @@
// cjdr_ctrl: sequencer for loads, clears and muon queries
// depends on cjdr_pkg; drives cjdr_dpath through cmd_t and reads status_t
`default_nettype none

module cjdr_ctrl
  import cjdr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic [1:0] kind,
  output      logic       in_ready,
  input  wire status_t    status,
  output      cmd_t       cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WALK  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_ROOT  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (kind)
            KIND_LOAD:  cmd.load  = 1'b1;
            KIND_CLEAR: cmd.clear = 1'b1;
            KIND_QUERY: begin
              cmd.start  = 1'b1;
              state_next = S_WALK;
            end
            default: ;
          endcase
        end
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (status.walk_end) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!status.pipe_busy) begin
          cmd.root_start = 1'b1;
          state_next     = S_ROOT;
        end
      end
      S_ROOT: begin
        if (!status.root_busy) begin
          cmd.fetch  = 1'b1;
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!status.out_full) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/cjdr_dpath.sv @@
// cjdr_dpath: jet table, distance pipeline, best tracker and output register
// depends on cjdr_pkg and cjdr_sqrt; commanded by cjdr_ctrl
`default_nettype none

module cjdr_dpath
  import cjdr_pkg::*;
#(
  parameter int unsigned MAX_JETS = MAX_JETS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire cmd_t                   cmd,
  output      status_t                status,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic signed [ETA_W-1:0] eta,
  input  wire logic signed [PHI_W-1:0] phi,
  input  wire logic [PT_W-1:0]        pt,
  input  wire logic [MASS_W-1:0]      mass,
  output      logic                   out_valid,
  input  wire logic                   out_ready,
  output      logic [DR_W-1:0]        dr,
  output      logic signed [DIFF_W-1:0] deta,
  output      logic signed [DIFF_W-1:0] dphi,
  output      logic [PT_W-1:0]        jet_pt,
  output      logic [MASS_W-1:0]      jet_mass,
  output      logic                   matched,
  output      logic                   jets_dropped
);

  localparam int unsigned AW     = (MAX_JETS > 1) ? $clog2(MAX_JETS) : 1;
  localparam int unsigned CW     = $clog2(MAX_JETS + 1);
  localparam int unsigned WORD_W = ETA_W + PHI_W + PT_W + MASS_W;
  localparam int unsigned DE_W   = ETA_W + 1;
  localparam int unsigned DP_W   = PHI_W + 2;
  localparam int unsigned AP_W   = 12;
  localparam int unsigned SQE_W  = 2 * ETA_W;
  localparam int unsigned SQP_W  = 2 * AP_W;
  localparam int unsigned SUM_W  = SQE_W + 1;
  localparam logic signed [DP_W-1:0] PI_W     = DP_W'(PI_FX);
  localparam logic signed [DP_W-1:0] TWO_PI_W = DP_W'(TWO_PI_FX);

  // configuration registers
  logic [CFG_DATA_W-1:0] cone_radius;
  logic [CFG_DATA_W-1:0] no_match_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      cone_radius    <= CONE_RADIUS_RST;
      no_match_value <= NO_MATCH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CONE_RADIUS: cone_radius    <= cfg_data;
        CFG_NO_MATCH:    no_match_value <= cfg_data;
        default: ;
      endcase
    end
  end

  // jet table: one word per jet, one write and one registered read port
  logic [WORD_W-1:0] jet_mem [MAX_JETS];
  logic [WORD_W-1:0] rd_word;
  logic [CW-1:0]     jet_count;
  logic              overflow;
  logic              full;
  logic [CW-1:0]     rd_idx;
  logic [AW-1:0]     best_idx;
  logic [AW-1:0]     rd_addr;
  logic              issue;

  assign full    = (jet_count == CW'(MAX_JETS));
  assign issue   = cmd.walk && (rd_idx != jet_count);
  assign rd_addr = cmd.fetch ? best_idx : rd_idx[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load && !full) begin
      jet_mem[jet_count[AW-1:0]] <= {eta, phi, pt, mass};
    end
    if (issue || cmd.fetch) begin
      rd_word <= jet_mem[rd_addr];
    end
  end

  // fill count and sticky drop flag
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      jet_count <= '0;
      overflow  <= 1'b0;
    end else if (cmd.load) begin
      if (full) begin
        overflow <= 1'b1;
      end else begin
        jet_count <= jet_count + 1'b1;
      end
    end
  end

  // walk address
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rd_idx <= '0;
    end else if (issue) begin
      rd_idx <= rd_idx + 1'b1;
    end
  end

  // muon word held for the walk
  logic signed [ETA_W-1:0] q_eta;
  logic signed [PHI_W-1:0] q_phi;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      q_eta <= eta;
      q_phi <= phi;
    end
  end

  // stage 1: differences, phi wrap, magnitudes
  logic                    v1, v2, v3;
  logic [AW-1:0]           idx1, idx2, idx3;
  logic signed [ETA_W-1:0] j_eta;
  logic signed [PHI_W-1:0] j_phi;
  logic signed [DE_W-1:0]  de_c, nde_c;
  logic signed [DP_W-1:0]  dpr_c, dpw_c, ndp_c;
  logic [ETA_W-1:0]        ae_c;
  logic [AP_W-1:0]         ap_c;

  assign j_eta = rd_word[WORD_W-1 -: ETA_W];
  assign j_phi = rd_word[WORD_W-ETA_W-1 -: PHI_W];

  always_comb begin
    de_c  = {q_eta[ETA_W-1], q_eta} - {j_eta[ETA_W-1], j_eta};
    dpr_c = {{2{q_phi[PHI_W-1]}}, q_phi} - {{2{j_phi[PHI_W-1]}}, j_phi};
    if (dpr_c >= PI_W) begin
      dpw_c = dpr_c - TWO_PI_W;
    end else if (dpr_c < -PI_W) begin
      dpw_c = dpr_c + TWO_PI_W;
    end else begin
      dpw_c = dpr_c;
    end
    nde_c = -de_c;
    ndp_c = -dpw_c;
    ae_c  = de_c[DE_W-1] ? nde_c[ETA_W-1:0] : de_c[ETA_W-1:0];
    ap_c  = dpw_c[DP_W-1] ? ndp_c[AP_W-1:0] : dpw_c[AP_W-1:0];
  end

  logic [ETA_W-1:0]         ae2;
  logic [AP_W-1:0]          ap2;
  logic signed [DIFF_W-1:0] de2, dp2, de3, dp3;
  logic [SQE_W-1:0]         sqe3;
  logic [SQP_W-1:0]         sqp3;

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // stage payload; stage 2 squares
  always_ff @(posedge clk) begin
    idx1 <= rd_idx[AW-1:0];
    idx2 <= idx1;
    ae2  <= ae_c;
    ap2  <= ap_c;
    de2  <= de_c[DIFF_W-1:0];
    dp2  <= dpw_c[DIFF_W-1:0];
    idx3 <= idx2;
    de3  <= de2;
    dp3  <= dp2;
    sqe3 <= SQE_W'(ae2) * SQE_W'(ae2);
    sqp3 <= SQP_W'(ap2) * SQP_W'(ap2);
  end

  // stage 3: sum and keep the first strict minimum
  logic [SUM_W-1:0]         sum3;
  logic [RAD_W-1:0]         best;
  logic                     found;
  logic signed [DIFF_W-1:0] best_de, best_dp;

  assign sum3 = {1'b0, sqe3} + SUM_W'(sqp3);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      best  <= RAD_W'(cone_radius) * RAD_W'(cone_radius);
      found <= 1'b0;
    end else if (v3 && (sum3 < SUM_W'(best))) begin
      best     <= sum3[RAD_W-1:0];
      found    <= 1'b1;
      best_de  <= de3;
      best_dp  <= dp3;
      best_idx <= idx3;
    end
  end

  // square root of the best distance
  logic              root_busy;
  logic [ROOT_W-1:0] root;

  cjdr_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.root_start),
    .radicand (best),
    .busy     (root_busy),
    .root     (root)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      jets_dropped <= overflow;
      matched      <= found;
      if (found) begin
        dr       <= root;
        deta     <= best_de;
        dphi     <= best_dp;
        jet_pt   <= rd_word[PT_W+MASS_W-1 -: PT_W];
        jet_mass <= rd_word[MASS_W-1:0];
      end else begin
        dr       <= no_match_value;
        deta     <= {1'b0, no_match_value};
        dphi     <= {1'b0, no_match_value};
        jet_pt   <= '0;
        jet_mass <= '0;
      end
    end
  end

  // status back to the controller
  always_comb begin
    status.walk_end  = (rd_idx == jet_count);
    status.pipe_busy = v1 || v2 || v3;
    status.root_busy = root_busy;
    status.out_full  = out_valid && !out_ready;
  end

endmodule

`default_nettype wire

@@ tb/cjdr_match_checker.sv @@
// cjdr_match_checker: watches the ports of the closest jet delta-r matcher,
// predicts every result word from its own jet table and flags differences
// depends on cjdr_pkg for widths, item kinds and register indexes
`timescale 1ns / 100ps

module cjdr_match_checker
  import cjdr_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic [1:0]               kind,
  input  logic signed [ETA_W-1:0]  eta,
  input  logic signed [PHI_W-1:0]  phi,
  input  logic [PT_W-1:0]          pt,
  input  logic [MASS_W-1:0]        mass,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic [DR_W-1:0]          dr,
  input  logic signed [DIFF_W-1:0] deta,
  input  logic signed [DIFF_W-1:0] dphi,
  input  logic [PT_W-1:0]          jet_pt,
  input  logic [MASS_W-1:0]        jet_mass,
  input  logic                     matched,
  input  logic                     jets_dropped,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  output int                       mismatch_count,
  output int                       pending_results,
  output int                       results_checked,
  output int                       matches_seen
);

  typedef struct packed {
    logic [DR_W-1:0]          dr;
    logic signed [DIFF_W-1:0] deta;
    logic signed [DIFF_W-1:0] dphi;
    logic [PT_W-1:0]          jet_pt;
    logic [MASS_W-1:0]        jet_mass;
    logic                     matched;
    logic                     jets_dropped;
  } match_word_t;

  // shadow jet table and registers
  logic signed [ETA_W-1:0] tbl_eta  [MAX_JETS_DEF];
  logic signed [PHI_W-1:0] tbl_phi  [MAX_JETS_DEF];
  logic [PT_W-1:0]         tbl_pt   [MAX_JETS_DEF];
  logic [MASS_W-1:0]       tbl_mass [MAX_JETS_DEF];
  int                      tbl_count;
  logic                    drop_flag;
  logic [CFG_DATA_W-1:0]   cone_q;
  logic [CFG_DATA_W-1:0]   no_match_q;

  match_word_t expected_q[$];
  match_word_t want;
  int          bad_words;
  int          field_errs;
  int          errs_prior;
  int          checked;
  int          hits;

  initial begin
    tbl_count  = 0;
    drop_flag  = 1'b0;
    cone_q     = CONE_RADIUS_RST;
    no_match_q = NO_MATCH_RST;
    bad_words  = 0;
    field_errs = 0;
    checked    = 0;
    hits       = 0;
  end

  // bitwise floor square root, one result bit per step
  function automatic logic [DR_W-1:0] floor_root(longint unsigned x);
    longint unsigned acc;
    longint unsigned trial;
    acc = 0;
    for (int b = DR_W - 1; b >= 0; b--) begin
      trial = acc | (64'd1 << b);
      if (trial * trial <= x) acc = trial;
    end
    return acc[DR_W-1:0];
  endfunction

  // nearest stored jet strictly inside the cone, earliest wins a tie
  function automatic match_word_t find_closest(logic signed [ETA_W-1:0] mu_eta,
                                                logic signed [PHI_W-1:0] mu_phi);
    longint      best;
    longint      sq_dist;
    longint      de;
    longint      dp;
    longint      win_de;
    longint      win_dp;
    int          win;
    bit          found;
    match_word_t w;
    best   = longint'(cone_q) * longint'(cone_q);
    found  = 1'b0;
    win    = 0;
    win_de = 0;
    win_dp = 0;
    for (int j = 0; j < tbl_count; j++) begin
      de = longint'(mu_eta) - longint'(tbl_eta[j]);
      dp = longint'(mu_phi) - longint'(tbl_phi[j]);
      while (dp >= PI_FX) dp -= TWO_PI_FX;
      while (dp < -PI_FX) dp += TWO_PI_FX;
      sq_dist = de * de + dp * dp;
      if (sq_dist < best) begin
        best   = sq_dist;
        found  = 1'b1;
        win    = j;
        win_de = de;
        win_dp = dp;
      end
    end
    if (found) begin
      w.dr       = floor_root(best);
      w.deta     = win_de[DIFF_W-1:0];
      w.dphi     = win_dp[DIFF_W-1:0];
      w.jet_pt   = tbl_pt[win];
      w.jet_mass = tbl_mass[win];
      w.matched  = 1'b1;
    end else begin
      w.dr       = no_match_q;
      w.deta     = {1'b0, no_match_q};
      w.dphi     = {1'b0, no_match_q};
      w.jet_pt   = '0;
      w.jet_mass = '0;
      w.matched  = 1'b0;
    end
    w.jets_dropped = drop_flag;
    return w;
  endfunction

  task automatic compare_field(string name, longint exp_val, longint got_val);
    if (exp_val != got_val) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, exp_val, got_val);
      field_errs++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      tbl_count  = 0;
      drop_flag  = 1'b0;
      cone_q     = CONE_RADIUS_RST;
      no_match_q = NO_MATCH_RST;
      expected_q.delete();
    end else begin
      // register writes
      if (cfg_we) begin
        if (cfg_index == CFG_CONE_RADIUS) cone_q = cfg_data;
        else if (cfg_index == CFG_NO_MATCH) no_match_q = cfg_data;
      end

      // result word against the oldest prediction
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t ns: result word with nothing outstanding, got dr %0d pt %0d",
                   $time, dr, jet_pt);
          bad_words++;
        end else begin
          want       = expected_q.pop_front();
          errs_prior = field_errs;
          compare_field("dr", longint'(want.dr), longint'(dr));
          compare_field("deta", longint'(want.deta), longint'(deta));
          compare_field("dphi", longint'(want.dphi), longint'(dphi));
          compare_field("jet_pt", longint'(want.jet_pt), longint'(jet_pt));
          compare_field("jet_mass", longint'(want.jet_mass), longint'(jet_mass));
          compare_field("matched", longint'(want.matched), longint'(matched));
          compare_field("jets_dropped", longint'(want.jets_dropped), longint'(jets_dropped));
          if (field_errs != errs_prior) bad_words++;
          checked++;
          if (want.matched) hits++;
        end
      end

      // accepted input word updates the table or raises a query
      if (in_valid && in_ready) begin
        case (kind)
          KIND_LOAD: begin
            if (tbl_count < MAX_JETS_DEF) begin
              tbl_eta[tbl_count]  = eta;
              tbl_phi[tbl_count]  = phi;
              tbl_pt[tbl_count]   = pt;
              tbl_mass[tbl_count] = mass;
              tbl_count++;
            end else begin
              drop_flag = 1'b1;
            end
          end
          KIND_QUERY: expected_q.push_back(find_closest(eta, phi));
          KIND_CLEAR: begin
            tbl_count = 0;
            drop_flag = 1'b0;
          end
          default: ;
        endcase
      end
    end
    mismatch_count  <= bad_words;
    pending_results <= expected_q.size();
    results_checked <= checked;
    matches_seen    <= hits;
  end

endmodule

@@ tb/tb_top.sv @@
// tb_top: stimulus and verdict for the closest jet delta-r matcher
// depends on cjdr_pkg, closest_jet_delta_r_match and cjdr_match_checker
`timescale 1ns / 100ps

module tb_top;
  import cjdr_pkg::*;

  localparam int ITEM_TARGET    = 1950;
  localparam int PHASES         = 6;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 40;

  // kind code with no meaning to the block
  localparam logic [1:0] KIND_SPARE = 2'd3;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [1:0]               kind = KIND_CLEAR;
  logic signed [ETA_W-1:0]  eta = '0;
  logic signed [PHI_W-1:0]  phi = '0;
  logic [PT_W-1:0]          pt = '0;
  logic [MASS_W-1:0]        mass = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [DR_W-1:0]          dr;
  logic signed [DIFF_W-1:0] deta;
  logic signed [DIFF_W-1:0] dphi;
  logic [PT_W-1:0]          jet_pt;
  logic [MASS_W-1:0]        jet_mass;
  logic                     matched;
  logic                     jets_dropped;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = CFG_CONE_RADIUS;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;

  int mismatch_count;
  int pending_results;
  int results_checked;
  int matches_seen;

  int items_sent = 0;
  int n_loads    = 0;
  int n_queries  = 0;
  int n_clears   = 0;
  int n_ignored  = 0;
  int n_settings = 0;
  int quiet_left = 0;
  int idle_cycles = 0;
  bit hold_req  = 1'b0;
  bit hold_done = 1'b0;

  // coordinates of the jets believed stored, used to aim queries and to repeat a jet
  typedef struct {
    int eta;
    int phi;
  } jet_pos_t;
  jet_pos_t placed_jets[$];

  closest_jet_delta_r_match i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .eta          (eta),
    .phi          (phi),
    .pt           (pt),
    .mass         (mass),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .dr           (dr),
    .deta         (deta),
    .dphi         (dphi),
    .jet_pt       (jet_pt),
    .jet_mass     (jet_mass),
    .matched      (matched),
    .jets_dropped (jets_dropped),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  cjdr_match_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .kind            (kind),
    .eta             (eta),
    .phi             (phi),
    .pt              (pt),
    .mass            (mass),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .dr              (dr),
    .deta            (deta),
    .dphi            (dphi),
    .jet_pt          (jet_pt),
    .jet_mass        (jet_mass),
    .matched         (matched),
    .jets_dropped    (jets_dropped),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results),
    .results_checked (results_checked),
    .matches_seen    (matches_seen)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // watchdog on cycles without any word moving
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t ns: no word moved for %0d cycles", $time, idle_cycles);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // result side: random stalls, one long hold-off when asked
  initial begin : result_sink
    int on_len;
    int off_len;
    int roll;
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        roll   = $urandom_range(0, 99);
        on_len = (roll < 20) ? $urandom_range(30, 120) : $urandom_range(1, 8);
        out_ready <= 1'b1;
        repeat (on_len) @(posedge clk);
        roll = $urandom_range(0, 99);
        if (roll < 55) off_len = 0;
        else if (roll < 92) off_len = $urandom_range(1, 4);
        else off_len = $urandom_range(10, 60);
        if (off_len > 0) begin
          out_ready <= 1'b0;
          repeat (off_len) @(posedge clk);
        end
      end
    end
  end

  // offer one input word after a random gap and wait for its acceptance
  task automatic send_word(logic [1:0] k, int e, int p, int t, int m);
    int gap;
    int roll;
    jet_pos_t pos;
    roll = $urandom_range(0, 99);
    if (quiet_left > 0) begin
      quiet_left--;
      gap = 0;
    end else if (roll < 4) begin
      quiet_left = $urandom_range(20, 80);
      gap = 0;
    end else if (roll < 60) gap = 0;
    else if (roll < 93) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    eta      <= e[ETA_W-1:0];
    phi      <= p[PHI_W-1:0];
    pt       <= t[PT_W-1:0];
    mass     <= m[MASS_W-1:0];
    do @(posedge clk); while (!in_ready);
    case (k)
      KIND_LOAD: begin
        n_loads++;
        items_sent++;
        if (placed_jets.size() < MAX_JETS_DEF) begin
          pos.eta = e;
          pos.phi = p;
          placed_jets.push_back(pos);
        end
      end
      KIND_QUERY: begin
        n_queries++;
        items_sent++;
      end
      KIND_CLEAR: begin
        n_clears++;
        items_sent++;
        placed_jets.delete();
      end
      default: n_ignored++;
    endcase
  endtask

  // jet mostly in a central window, sometimes anywhere, sometimes a duplicate
  task automatic load_jet();
    int e;
    int p;
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10 && placed_jets.size() > 0) begin
      e = placed_jets[placed_jets.size() - 1].eta;
      p = placed_jets[placed_jets.size() - 1].phi;
    end else if (roll < 25) begin
      e = $urandom_range(0, 65535) - 32768;
      p = $urandom_range(0, 8191) - 4096;
    end else begin
      e = $urandom_range(0, 8191) - 4096;
      p = $urandom_range(0, 6434) - 3217;
    end
    send_word(KIND_LOAD, e, p, $urandom_range(0, 65535), $urandom_range(0, 65535));
  endtask

  // muon mostly aimed near a stored jet
  task automatic query_muon();
    int e;
    int p;
    int k;
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 75 && placed_jets.size() > 0) begin
      k = $urandom_range(0, placed_jets.size() - 1);
      e = placed_jets[k].eta;
      p = placed_jets[k].phi;
      if ($urandom_range(0, 99) >= 15) begin
        e += $urandom_range(0, 700) - 350;
        p += $urandom_range(0, 700) - 350;
      end
    end else if (roll < 85) begin
      e = $urandom_range(0, 65535) - 32768;
      p = $urandom_range(0, 8191) - 4096;
    end else begin
      e = $urandom_range(0, 8191) - 4096;
      p = $urandom_range(0, 6434) - 3217;
    end
    send_word(KIND_QUERY, e, p, $urandom_range(0, 65535), $urandom_range(0, 65535));
  endtask

  task automatic random_word();
    send_word(2'($urandom_range(0, 3)), $urandom_range(0, 65535),
              $urandom_range(0, 8191), $urandom_range(0, 65535), $urandom_range(0, 65535));
  endtask

  // one event: clear, fill, query; some without a clear, some noise
  task automatic run_sequence();
    int roll;
    int n_jets;
    int n_muons;
    roll = $urandom_range(0, 99);
    if (roll < 88) begin
      if (roll < 78)
        send_word(KIND_CLEAR, $urandom_range(0, 65535), $urandom_range(0, 8191),
                  $urandom_range(0, 65535), $urandom_range(0, 65535));
      n_jets  = ($urandom_range(0, 99) < 15) ? $urandom_range(30, 36) : $urandom_range(0, 8);
      n_muons = $urandom_range(1, 6);
      repeat (n_jets) load_jet();
      repeat (n_muons) query_muon();
    end else begin
      repeat ($urandom_range(1, 3)) random_word();
    end
  endtask

  // let the block drain so registers change only while idle
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(logic [CFG_DATA_W-1:0] cone, logic [CFG_DATA_W-1:0] no_match);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CONE_RADIUS;
    cfg_data  <= cone;
    @(posedge clk);
    cfg_index <= CFG_NO_MATCH;
    cfg_data  <= no_match;
    @(posedge clk);
    cfg_we    <= 1'b0;
    n_settings++;
  endtask

  // hand-picked words under the reset cone of 410
  task automatic directed_words();
    send_word(KIND_CLEAR, 0, 0, 0, 0);
    send_word(KIND_QUERY, 0, 0, 0, 0);                   // empty table
    send_word(KIND_SPARE, -1, -1, 65535, 65535);         // unused kind
    send_word(KIND_LOAD, 0, 0, 65535, 0);
    send_word(KIND_LOAD, 0, 0, 1, 65535);                // same spot, must lose the tie
    send_word(KIND_QUERY, 0, 0, 0, 0);                   // zero distance
    send_word(KIND_QUERY, 410, 0, 0, 0);                 // on the cone edge
    send_word(KIND_QUERY, 409, 0, 0, 0);                 // just inside
    send_word(KIND_QUERY, -200, 300, 0, 0);
    send_word(KIND_CLEAR, 0, 0, 0, 0);
    send_word(KIND_LOAD, 32767, 3217, 100, 200);
    send_word(KIND_LOAD, -32768, -3217, 300, 400);
    send_word(KIND_LOAD, 0, -4096, 500, 600);            // phi beyond pi
    send_word(KIND_QUERY, 32767, -3217, 0, 0);           // wraps to zero dphi
    send_word(KIND_QUERY, -32768, 3216, 0, 0);           // wraps to -1
    send_word(KIND_QUERY, 0, 2300, 0, 0);                // wraps against phi beyond pi
    send_word(KIND_QUERY, 0, 4095, 0, 0);
    send_word(KIND_QUERY, -32768, 4095, 65535, 65535);
  endtask

  int cone_set [PHASES];
  int nm_set   [PHASES];

  initial begin
    cone_set = '{410, 0, 4095, 0, 1, 410};
    nm_set   = '{512, 4095, 0, 0, 0, 512};
    cone_set[3] = $urandom_range(200, 2000);
    nm_set[3]   = $urandom_range(0, 4095);
    nm_set[4]   = $urandom_range(0, 4095);

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 0) begin
        directed_words();
      end else begin
        settle();
        write_regs(CFG_DATA_W'(cone_set[ph]), CFG_DATA_W'(nm_set[ph]));
      end
      // long result hold-off while words keep coming
      if (ph == 2) hold_req = 1'b1;
      while (items_sent < (ph + 1) * ITEM_TARGET / PHASES) run_sequence();
    end
    settle();

    $display("covered %0d loads, %0d clears, %0d queries and %0d unused-kind words",
             n_loads, n_clears, n_queries, n_ignored);
    $display("%0d register settings written, %0d results checked, %0d inside the cone",
             n_settings, results_checked, matches_seen);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d result words mismatched", mismatch_count);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
